@@ rtl/bdil_pkg.sv @@
`timescale 1ns / 1ps

package bdil_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int KERNEL_W  = 9;
  localparam int IWIDTH_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 9;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  // cross shape
  localparam logic [KERNEL_W-1:0] KERNEL_RESET = 9'd186;
  localparam logic [IWIDTH_W-1:0] IWIDTH_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL = 2'd0,
    REG_IWIDTH = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [MAX_WIDTH-1:0] row_pixels;
    logic                 last_row;
  } in_word_t;

  typedef struct packed {
    logic [MAX_WIDTH-1:0] dilated_row;
    logic                 frame_end;
  } out_word_t;

  // one accepted row as seen by the back end
  typedef struct packed {
    logic [MAX_WIDTH-1:0] above;
    logic [MAX_WIDTH-1:0] pending;
    logic [MAX_WIDTH-1:0] row;
    logic                 pend_valid;
    logic                 last;
  } dil_cmd_t;

  function automatic logic [MAX_WIDTH-1:0] width_mask(input logic [IWIDTH_W-1:0] w);
    logic [MAX_WIDTH-1:0] m;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      m[i] = (IWIDTH_W'(i) < w);
    end
    return m;
  endfunction

  function automatic logic [MAX_WIDTH-1:0] spread(input logic [MAX_WIDTH-1:0] src,
                                                  input logic [2:0] krow);
    logic [MAX_WIDTH-1:0] r;
    r = '0;
    if (krow[0]) r = r | (src >> 1);
    if (krow[1]) r = r | src;
    if (krow[2]) r = r | (src << 1);
    return r;
  endfunction

  function automatic logic [MAX_WIDTH-1:0] dilate_row(input logic [KERNEL_W-1:0] k,
                                                      input logic [IWIDTH_W-1:0] w,
                                                      input logic [MAX_WIDTH-1:0] top,
                                                      input logic [MAX_WIDTH-1:0] mid,
                                                      input logic [MAX_WIDTH-1:0] bot);
    logic [MAX_WIDTH-1:0] r;
    r = spread(top, k[8:6]) | spread(mid, k[5:3]) | mid | spread(bot, k[2:0]);
    return r & width_mask(w);
  endfunction

endpackage

@@ rtl/bdil_front.sv @@
`timescale 1ns / 1ps

module bdil_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bdil_pkg::in_word_t               in_word,
  input  logic [bdil_pkg::IWIDTH_W-1:0]    image_width,
  input  logic                             q_full,
  output logic                             q_push,
  output bdil_pkg::dil_cmd_t               q_cmd
);

  logic [bdil_pkg::MAX_WIDTH-1:0] above;
  logic [bdil_pkg::MAX_WIDTH-1:0] pending;
  logic                           pend_valid;
  logic [bdil_pkg::MAX_WIDTH-1:0] row_m;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign row_m    = in_word.row_pixels & bdil_pkg::width_mask(image_width);

  always_comb begin
    q_cmd.above      = above;
    q_cmd.pending    = pending;
    q_cmd.row        = row_m;
    q_cmd.pend_valid = pend_valid;
    q_cmd.last       = in_word.last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above      <= '0;
      pending    <= '0;
      pend_valid <= 1'b0;
    end else if (q_push) begin
      if (in_word.last_row) begin
        above      <= '0;
        pending    <= '0;
        pend_valid <= 1'b0;
      end else begin
        above      <= pend_valid ? pending : '0;
        pending    <= row_m;
        pend_valid <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/bdil_fifo.sv @@
`timescale 1ns / 1ps

module bdil_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bdil_pkg::dil_cmd_t  push_cmd,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output bdil_pkg::dil_cmd_t  head
);

  bdil_pkg::dil_cmd_t             mem [bdil_pkg::QDEPTH];
  logic [bdil_pkg::QPTR_W-1:0]    wptr;
  logic [bdil_pkg::QPTR_W-1:0]    rptr;
  logic [bdil_pkg::QCNT_W-1:0]    count;

  assign full       = (count == bdil_pkg::QCNT_W'(bdil_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= bdil_pkg::QCNT_W'(bdil_pkg::QDEPTH))
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || full) |-> (wptr == rptr))
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/bdil_back.sv @@
`timescale 1ns / 1ps

module bdil_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [bdil_pkg::KERNEL_W-1:0]    kernel_bits,
  input  logic [bdil_pkg::IWIDTH_W-1:0]    image_width,
  input  logic                             head_valid,
  input  bdil_pkg::dil_cmd_t               head,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bdil_pkg::out_word_t              out_word
);

  // phase set: first word of a two-word last row already sent
  logic                           phase;
  logic                           phase_next;
  logic                           can_load;
  logic                           load;
  logic [bdil_pkg::MAX_WIDTH-1:0] top;
  logic [bdil_pkg::MAX_WIDTH-1:0] mid;
  logic [bdil_pkg::MAX_WIDTH-1:0] bot;
  logic                           fend;

  assign can_load = !out_valid || !out_stall;

  always_comb begin
    pop        = 1'b0;
    load       = 1'b0;
    phase_next = phase;
    top        = head.above;
    mid        = head.pending;
    bot        = head.row;
    fend       = 1'b0;
    if (head_valid && can_load) begin
      if (phase) begin
        top        = head.pending;
        mid        = head.row;
        bot        = '0;
        fend       = 1'b1;
        load       = 1'b1;
        pop        = 1'b1;
        phase_next = 1'b0;
      end else if (head.pend_valid) begin
        load = 1'b1;
        if (head.last) begin
          phase_next = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else if (head.last) begin
        // single-row frame
        top  = '0;
        mid  = head.row;
        bot  = '0;
        fend = 1'b1;
        load = 1'b1;
        pop  = 1'b1;
      end else begin
        // first row of a frame gives nothing yet
        pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word.dilated_row <= bdil_pkg::dilate_row(kernel_bits, image_width, top, mid, bot);
      out_word.frame_end   <= fend;
    end
  end

  a_phase_cmd: assert property (@(posedge clk) disable iff (rst)
    phase |-> (head_valid && head.last && head.pend_valid))
    else $error("second phase without a two-word last row");
  a_phase_pop: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !phase && head.pend_valid && head.last) |-> !pop)
    else $error("two-word last row popped early");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load)
    else $error("stalled output overwritten");

endmodule

@@ rtl/binary_dilation_3x3.sv @@
`timescale 1ns / 1ps
// a row that completes a result word goes through the command queue, and the back end then
//   registers the word in its output register; the first row of a frame gives no word and the
//   last row of a longer frame gives two, so the four-entry command queue soaks up the extra
//   work over short bursts, while a steady run of short frames stalls the input
// reset: synchronous active-high rst clears the queue, row history and output valid,
//   and restores the cross kernel and a width of 64

module binary_dilation_3x3 (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bdil_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bdil_pkg::out_word_t              out_word,
  input  logic                             cfg_we,
  input  logic [bdil_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdil_pkg::CFG_W-1:0]       cfg_data
);

  logic [bdil_pkg::KERNEL_W-1:0] kernel_bits;
  logic [bdil_pkg::IWIDTH_W-1:0] image_width;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_full;
  logic                          q_head_valid;
  bdil_pkg::dil_cmd_t            q_cmd;
  bdil_pkg::dil_cmd_t            q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_bits <= bdil_pkg::KERNEL_RESET;
      image_width <= bdil_pkg::IWIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bdil_pkg::REG_KERNEL: kernel_bits <= cfg_data[bdil_pkg::KERNEL_W-1:0];
        bdil_pkg::REG_IWIDTH: image_width <= cfg_data[bdil_pkg::IWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  bdil_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .image_width (image_width),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  bdil_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  bdil_back u_back (
    .clk         (clk),
    .rst         (rst),
    .kernel_bits (kernel_bits),
    .image_width (image_width),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

@@ bench/dilation_checker.sv @@
`timescale 1ns / 1ps

module dilation_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  bdil_pkg::in_word_t             in_word,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  bdil_pkg::out_word_t            out_word,
  input  logic                           cfg_we,
  input  logic [bdil_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdil_pkg::CFG_W-1:0]     cfg_data,
  output int                             rows_due,
  output int                             rows_checked,
  output int                             mismatches
);

  logic [bdil_pkg::KERNEL_W-1:0]  kern = bdil_pkg::KERNEL_RESET;
  logic [bdil_pkg::IWIDTH_W-1:0]  cols = bdil_pkg::IWIDTH_RESET;
  logic [bdil_pkg::MAX_WIDTH-1:0] upper_src = '0;
  logic [bdil_pkg::MAX_WIDTH-1:0] held_src = '0;
  logic                           held_ok = 1'b0;
  bdil_pkg::out_word_t            due_rows[$];

  function automatic logic [bdil_pkg::MAX_WIDTH-1:0] col_mask(
      input logic [bdil_pkg::IWIDTH_W-1:0] w);
    if (w >= bdil_pkg::MAX_WIDTH) return '1;
    return ~({bdil_pkg::MAX_WIDTH{1'b1}} << w);
  endfunction

  // taps[0] reaches one column left, taps[2] one column right
  function automatic logic [bdil_pkg::MAX_WIDTH-1:0] smear(
      input logic [bdil_pkg::MAX_WIDTH-1:0] src, input logic [2:0] taps);
    return ({bdil_pkg::MAX_WIDTH{taps[0]}} & (src >> 1)) |
           ({bdil_pkg::MAX_WIDTH{taps[1]}} & src) |
           ({bdil_pkg::MAX_WIDTH{taps[2]}} & (src << 1));
  endfunction

  // the row above is hit by the bottom row of the element, the row below by the top row
  function automatic logic [bdil_pkg::MAX_WIDTH-1:0] grow(
      input logic [bdil_pkg::MAX_WIDTH-1:0] top,
      input logic [bdil_pkg::MAX_WIDTH-1:0] mid,
      input logic [bdil_pkg::MAX_WIDTH-1:0] bot);
    return (smear(top, kern[8:6]) | smear(mid, kern[5:3]) | mid | smear(bot, kern[2:0]))
           & col_mask(cols);
  endfunction

  task automatic flag(input string what, input logic [bdil_pkg::MAX_WIDTH-1:0] got,
                      input logic [bdil_pkg::MAX_WIDTH-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic take_row(input bdil_pkg::in_word_t w);
    logic [bdil_pkg::MAX_WIDTH-1:0] r;
    bdil_pkg::out_word_t            e;
    r = w.row_pixels & col_mask(cols);
    if (held_ok) begin
      e.dilated_row = grow(upper_src, held_src, r);
      e.frame_end   = 1'b0;
      due_rows.push_back(e);
      upper_src = held_src;
    end else begin
      upper_src = '0;
    end
    held_src = r;
    held_ok  = 1'b1;
    if (w.last_row) begin
      e.dilated_row = grow(upper_src, held_src, '0);
      e.frame_end   = 1'b1;
      due_rows.push_back(e);
      upper_src = '0;
      held_src  = '0;
      held_ok   = 1'b0;
    end
  endtask

  task automatic check_row(input bdil_pkg::out_word_t got);
    bdil_pkg::out_word_t want;
    if (due_rows.size() == 0) begin
      flag("unexpected word", got.dilated_row, '0);
    end else begin
      want = due_rows.pop_front();
      if (got.dilated_row !== want.dilated_row)
        flag("dilated_row", got.dilated_row, want.dilated_row);
      if (got.frame_end !== want.frame_end)
        flag("frame_end", bdil_pkg::MAX_WIDTH'(got.frame_end),
             bdil_pkg::MAX_WIDTH'(want.frame_end));
    end
    rows_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kern      = bdil_pkg::KERNEL_RESET;
      cols      = bdil_pkg::IWIDTH_RESET;
      upper_src = '0;
      held_src  = '0;
      held_ok   = 1'b0;
      due_rows.delete();
    end else begin
      if (out_valid && !out_stall) check_row(out_word);
      if (in_valid && !in_stall) take_row(in_word);
      if (cfg_we) begin
        case (cfg_index)
          bdil_pkg::REG_KERNEL: kern = cfg_data[bdil_pkg::KERNEL_W-1:0];
          bdil_pkg::REG_IWIDTH: cols = cfg_data[bdil_pkg::IWIDTH_W-1:0];
          default: ;
        endcase
      end
    end
    rows_due <= due_rows.size();
  end

  always @(posedge clk) begin
    if (!rst && in_valid !== 1'b1 && in_valid !== 1'b0) flag("in_valid", '0, '0);
  end

endmodule

@@ bench/tb_binary_dilation_3x3.sv @@
`timescale 1ns / 1ps

module tb_binary_dilation_3x3;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = 8;
  localparam logic [bdil_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [bdil_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  bdil_pkg::in_word_t             in_word = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  bdil_pkg::out_word_t            out_word;
  logic                           cfg_we = 1'b0;
  logic [bdil_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bdil_pkg::CFG_W-1:0]     cfg_data = '0;

  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  int   quiet = 0;
  int   rows_sent = 0;
  int   frames_sent = 0;
  int   reg_writes = 0;
  int   rows_due;
  int   rows_checked;
  int   mismatches;

  binary_dilation_3x3 dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dilation_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rows_due     (rows_due),
    .rows_checked (rows_checked),
    .mismatches   (mismatches)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("no word moved for %0d cycles", quiet);
      $display("** binary_dilation_3x3: FAILED **");
      $finish;
    end
  end

  function automatic logic [bdil_pkg::MAX_WIDTH-1:0] pick_row();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      3: return ~(64'd1 << $urandom_range(63));
      4: return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [bdil_pkg::CFG_W-1:0] pick_kernel();
    case ($urandom_range(7))
      0: return '0;
      1: return 9'h1FF;
      2: return bdil_pkg::KERNEL_RESET;
      3: return 9'd1 << $urandom_range(8);
      default: return bdil_pkg::CFG_W'($urandom_range(511));
    endcase
  endfunction

  // upper data bits are junk that the width register must drop
  function automatic logic [bdil_pkg::CFG_W-1:0] pick_width();
    logic [bdil_pkg::CFG_W-1:0] v;
    v = bdil_pkg::CFG_W'($urandom);
    case ($urandom_range(9))
      0: v[bdil_pkg::IWIDTH_W-1:0] = 7'd0;
      1: v[bdil_pkg::IWIDTH_W-1:0] = 7'd1;
      2: v[bdil_pkg::IWIDTH_W-1:0] = 7'd64;
      3: v[bdil_pkg::IWIDTH_W-1:0] = 7'h7F;
      4: v[bdil_pkg::IWIDTH_W-1:0] = 7'($urandom_range(65, 127));
      5: v[bdil_pkg::IWIDTH_W-1:0] = 7'($urandom_range(1, 4));
      default: v[bdil_pkg::IWIDTH_W-1:0] = 7'($urandom_range(1, 64));
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [bdil_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdil_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // sender pause: wait out every pending result, then let the back end go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_row(input logic [bdil_pkg::MAX_WIDTH-1:0] px, input logic last);
    bdil_pkg::in_word_t w;
    w.row_pixels = px;
    w.last_row   = last;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rows_sent++;
    if (last) frames_sent++;
  endtask

  task automatic send_frame(input int len, input bit retune);
    for (int i = 0; i < len; i++) begin
      // mid-frame register change, done while nothing is in flight
      if (retune && i == len / 2 && i > 0) begin
        settle();
        if ($urandom_range(1)) write_reg(bdil_pkg::REG_IWIDTH, pick_width());
        else write_reg(bdil_pkg::REG_KERNEL, pick_kernel());
      end
      send_row(pick_row(), i == len - 1);
    end
  endtask

  task automatic random_phase(input int count);
    int goal;
    int len;
    goal = rows_sent + count;
    while (rows_sent < goal) begin
      if ($urandom_range(3) == 0) begin
        settle();
        write_reg(bdil_pkg::REG_KERNEL, pick_kernel());
        write_reg(bdil_pkg::REG_IWIDTH, pick_width());
        if ($urandom_range(7) == 0)
          write_reg(REG_SPARE_A + bdil_pkg::CFG_IDX_W'($urandom_range(1)),
                    bdil_pkg::CFG_W'($urandom));
      end
      len = ($urandom_range(7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
      send_frame(len, $urandom_range(9) == 0);
    end
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: cross element, full width
    send_row('1, 1'b1);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b1);
    settle();
    // empty element: only the source pixels stay white
    write_reg(bdil_pkg::REG_KERNEL, '0);
    send_row(64'h0123_4567_89AB_CDEF, 1'b0);
    send_row('1, 1'b1);
    settle();
    write_reg(bdil_pkg::REG_KERNEL, 9'h1FF);
    write_reg(bdil_pkg::REG_IWIDTH, 9'd1);
    send_row('1, 1'b0);
    send_row('0, 1'b0);
    send_row('1, 1'b1);
    settle();
    // zero width empties every row
    write_reg(bdil_pkg::REG_IWIDTH, 9'd0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    settle();
    // width above the row saturates, writes past the last register are dropped
    write_reg(bdil_pkg::REG_IWIDTH, 9'h7F);
    write_reg(REG_SPARE_A, '0);
    write_reg(REG_SPARE_B, 9'h1F0);
    send_row(64'h0000_0001_0000_0000, 1'b0);
    send_row(64'h8000_0000_0000_0000, 1'b0);
    send_row('0, 1'b1);
    settle();
    write_reg(bdil_pkg::REG_IWIDTH, 9'd64);
    write_reg(bdil_pkg::REG_KERNEL, bdil_pkg::KERNEL_RESET);
    send_row({$urandom, $urandom}, 1'b0);
    send_row('1, 1'b0);
    settle();
    // width shrinks under stored rows
    write_reg(bdil_pkg::REG_IWIDTH, 9'd10);
    send_row('1, 1'b0);
    send_row(64'h0000_0000_0000_0200, 1'b1);
    settle();

    snd_idle_pct = 8;
    rcv_idle_pct = 76;
    random_phase(270);

    snd_idle_pct = 76;
    rcv_idle_pct = 8;
    random_phase(270);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(bdil_pkg::REG_KERNEL, 9'h1FF);
    write_reg(bdil_pkg::REG_IWIDTH, 9'd64);
    // long receiver hold-off while rows keep coming, so the input backs up
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int f = 0; f < 8; f++) send_frame(5, 1'b0);
    settle();
    random_phase(230);

    $display("run covered %0d rows in %0d frames, %0d dilated rows checked",
             rows_sent, frames_sent, rows_checked);
    $display("%0d register writes: empty, full and one-hot elements, widths 0 to 127",
             reg_writes);
    if (mismatches == 0) begin
      $display("** binary_dilation_3x3: PASSED **");
    end else begin
      $display("** binary_dilation_3x3: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bdil_pkg.sv
rtl/bdil_front.sv
rtl/bdil_fifo.sv
rtl/bdil_back.sv
rtl/binary_dilation_3x3.sv
bench/dilation_checker.sv
bench/tb_binary_dilation_3x3.sv
